@@ design/bdq_pkg.sv @@
package bdq_pkg;

  // Deque geometry
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  // Operation codes carried on the mode field
  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_BACK  = 3'd3,
    MODE_SEARCH    = 3'd4,
    MODE_DUMP      = 3'd5
  } mode_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_FOUND   = 3'd3,
    ST_MISSING = 3'd4,
    ST_INVALID = 3'd5
  } status_e;

  // Storage access issued by the sequencer
  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
  } mem_req_t;

  // One result handed to the output register
  typedef struct packed {
    logic                     valid;
    status_e                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } res_t;

  // Circular slot: (base + off) mod CAPACITY, both operands below CAPACITY
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ design/bdq_store.sv @@
module bdq_store
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  mem_req_t                 req_i,
  output logic signed [DATA_W-1:0] rd_data_o
);

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/bdq_seq.sv @@
module bdq_seq
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               mode_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  input  logic                     out_free_i,
  input  logic signed [DATA_W-1:0] rd_data_i,
  output mem_req_t                 mem_o,
  output res_t                     res_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [2:0]               mode_q, mode_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic [IDX_W-1:0]         front_q, front_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         idx_q, idx_d;

  logic             full;
  logic             empty;
  logic             last_entry;
  logic             hit;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] front_dec;

  assign full       = (count_q == CNT_W'(CAPACITY));
  assign empty      = (count_q == '0);
  assign count_m1   = count_q - CNT_W'(1);
  assign last_entry = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign front_dec  = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);
  // Shared comparator for the search walk
  assign hit        = (rd_data_i == key_q);

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    key_d   = key_q;
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    mem_o   = '0;
    res_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          key_d   = value_in_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        case (mode_e'(mode_q)) inside
          MODE_INS_FRONT, MODE_INS_BACK: begin
            if (out_free_i) begin
              res_o.valid  = 1'b1;
              res_o.last   = 1'b1;
              res_o.status = full ? ST_FULL : ST_DONE;
              if (!full) begin
                mem_o.wr_en   = 1'b1;
                mem_o.wr_data = key_q;
                count_d       = count_q + CNT_W'(1);
                if (mode_e'(mode_q) == MODE_INS_FRONT) begin
                  mem_o.wr_addr = front_dec;
                  front_d       = front_dec;
                end else begin
                  mem_o.wr_addr = slot_add(front_q, IDX_W'(count_q));
                end
              end
              state_d = S_IDLE;
            end
          end
          MODE_REM_FRONT, MODE_REM_BACK: begin
            if (empty) begin
              if (out_free_i) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              mem_o.rd_en   = 1'b1;
              mem_o.rd_addr = (mode_e'(mode_q) == MODE_REM_FRONT) ? front_q :
                              slot_add(front_q, IDX_W'(count_m1));
              state_d       = S_READ;
            end
          end
          MODE_SEARCH, MODE_DUMP: begin
            if (empty) begin
              if (out_free_i) begin
                res_o.valid  = 1'b1;
                res_o.last   = 1'b1;
                res_o.status = ST_EMPTY;
                state_d      = S_IDLE;
              end
            end else begin
              mem_o.rd_en   = 1'b1;
              mem_o.rd_addr = front_q;
              idx_d         = '0;
              state_d       = S_SCAN;
            end
          end
          default: begin
            if (out_free_i) begin
              res_o.valid  = 1'b1;
              res_o.last   = 1'b1;
              res_o.status = ST_INVALID;
              state_d      = S_IDLE;
            end
          end
        endcase
      end

      // Return the removed entry and retire it
      S_READ: begin
        if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.last   = 1'b1;
          res_o.status = ST_DONE;
          res_o.value  = rd_data_i;
          count_d      = count_m1;
          if (mode_e'(mode_q) == MODE_REM_FRONT) begin
            front_d = slot_add(front_q, IDX_W'(1));
          end
          state_d = S_IDLE;
        end
      end

      // Walk the window one entry a cycle while the output register is free
      S_SCAN: begin
        if (mode_e'(mode_q) == MODE_SEARCH) begin
          if (hit || last_entry) begin
            if (out_free_i) begin
              res_o.valid  = 1'b1;
              res_o.last   = 1'b1;
              res_o.status = hit ? ST_FOUND : ST_MISSING;
              res_o.value  = key_q;
              state_d      = S_IDLE;
            end
          end else begin
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = slot_add(front_q, idx_q + IDX_W'(1));
            idx_d         = idx_q + IDX_W'(1);
          end
        end else if (out_free_i) begin
          res_o.valid  = 1'b1;
          res_o.last   = last_entry;
          res_o.status = ST_DONE;
          res_o.value  = rd_data_i;
          if (last_entry) begin
            state_d = S_IDLE;
          end else begin
            mem_o.rd_en   = 1'b1;
            mem_o.rd_addr = slot_add(front_q, idx_q + IDX_W'(1));
            idx_d         = idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Request and walk registers
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("result issued into an occupied output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted request not executed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(res_o.valid) && $past(res_o.status) == ST_DONE))
    else $error("entry count moved without a completed request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(idx_q) < count_q))
    else $error("walk index outside occupied window");
`endif

endmodule

@@ design/bounded_deque_with_search_top.sv @@
// Channel  Handshake               Payload
// in       in_valid_i / in_ready_o  mode_i[2:0], value_in_i[31:0]
// out      out_valid_o / out_ready_i status_o[2:0], value_out_o[31:0], last_o
//
// Insert, invalid and empty-list requests pass through the execute state alone,
// and remove adds a read state; search and dump walk the window through the
// single storage read port, one entry a cycle while the consumer keeps up.
// A new request is taken only while the sequencer is idle.
// Results sit in one output register; a stalled consumer stalls the walk.
// Reset clears the front pointer and count; storage needs no clearing.
module bounded_deque_with_search_top
  import bdq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [2:0]               mode_i,
  input  logic signed [DATA_W-1:0] value_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic signed [DATA_W-1:0] value_out_o,
  output logic                     last_o
);

  mem_req_t                 mem_req;
  res_t                     res;
  logic signed [DATA_W-1:0] rd_data;
  logic                     out_free;

  logic                     out_valid_q;
  status_e                  status_q;
  logic signed [DATA_W-1:0] value_q;
  logic                     last_q;

  assign out_free = !out_valid_q || out_ready_i;

  bdq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .value_in_i (value_in_i),
    .out_free_i (out_free),
    .rd_data_i  (rd_data),
    .mem_o      (mem_req),
    .res_o      (res)
  );

  bdq_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      value_q  <= res.value;
      last_q   <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_out_o = value_q;
  assign last_o      = last_q;

endmodule

@@ tb/tb.sv @@
module tb;
  import bdq_pkg::*;

  // Mode codes left undefined by the operation set
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  localparam int NUM_ROWS         = 24;
  localparam int RANDOM_PER_PHASE = 26;
  localparam int HOLD_CYCLES      = 200;
  localparam int MAX_PRINTS       = 30;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 40;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } deque_result_t;

  // One line of the directed table; a typed row carries a single known result
  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    int                       reps;
    bit                       typed;
    status_e                  status;
    logic signed [DATA_W-1:0] result;
  } request_row_t;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [2:0]               mode      = '0;
  logic signed [DATA_W-1:0] value_in  = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] value_out;
  logic                     last;

  // Predictor state: shadow of the circular store
  logic signed [DATA_W-1:0] entries [CAPACITY];
  int unsigned              head      = 0;
  int unsigned              occupancy = 0;

  deque_result_t predicted [$];
  deque_result_t expected_results [$];

  int  tx_idle_pct     = 0;
  int  rx_idle_pct     = 0;
  bit  hold_go         = 1'b0;
  int  mismatches      = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  dump_lines      = 0;
  int  refused_inserts = 0;
  int  empty_reports   = 0;
  int  peak_occupancy  = 0;

  request_row_t directed_rows [NUM_ROWS] = '{
    '{MODE_REM_FRONT, 32'sd0,          1,  1'b1, ST_EMPTY,   32'sd0},
    '{MODE_REM_BACK,  32'sd0,          1,  1'b1, ST_EMPTY,   32'sd0},
    '{MODE_SEARCH,    32'sd5,          1,  1'b1, ST_EMPTY,   32'sd0},
    '{MODE_DUMP,      32'sd0,          1,  1'b1, ST_EMPTY,   32'sd0},
    '{MODE_RSVD_6,    32'sh12345678,   1,  1'b1, ST_INVALID, 32'sd0},
    '{MODE_RSVD_7,    -32'sd1,         1,  1'b1, ST_INVALID, 32'sd0},
    '{MODE_INS_BACK,  32'sh7FFFFFFF,   1,  1'b1, ST_DONE,    32'sd0},
    '{MODE_INS_FRONT, 32'sh80000000,   1,  1'b1, ST_DONE,    32'sd0},
    '{MODE_INS_BACK,  32'sd0,          1,  1'b1, ST_DONE,    32'sd0},
    '{MODE_INS_FRONT, -32'sd1,         1,  1'b1, ST_DONE,    32'sd0},
    '{MODE_SEARCH,    32'sh80000000,   1,  1'b1, ST_FOUND,   32'sh80000000},
    '{MODE_SEARCH,    32'sd1234,       1,  1'b1, ST_MISSING, 32'sd1234},
    '{MODE_DUMP,      32'sd0,          1,  1'b0, ST_DONE,    32'sd0},
    '{MODE_INS_BACK,  -32'sd1,         1,  1'b1, ST_DONE,    32'sd0},
    '{MODE_SEARCH,    -32'sd1,         1,  1'b1, ST_FOUND,   -32'sd1},
    '{MODE_REM_BACK,  32'sd0,          1,  1'b0, ST_DONE,    32'sd0},
    '{MODE_REM_FRONT, 32'sd0,          1,  1'b0, ST_DONE,    32'sd0},
    '{MODE_INS_BACK,  32'sh55555550,   13, 1'b0, ST_DONE,    32'sd0},
    '{MODE_INS_FRONT, 32'sd7,          1,  1'b1, ST_FULL,    32'sd0},
    '{MODE_INS_BACK,  32'sd7,          1,  1'b1, ST_FULL,    32'sd0},
    '{MODE_DUMP,      32'sd0,          1,  1'b0, ST_DONE,    32'sd0},
    '{MODE_SEARCH,    32'sh5555555C,   1,  1'b1, ST_FOUND,   32'sh5555555C},
    '{MODE_REM_FRONT, 32'sd0,          16, 1'b0, ST_DONE,    32'sd0},
    '{MODE_REM_BACK,  32'sd0,          1,  1'b1, ST_EMPTY,   32'sd0}
  };

  bounded_deque_with_search_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (mode),
    .value_in_i  (value_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .value_out_o (value_out),
    .last_o      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("tb: mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic int unsigned slot(input int unsigned off);
    return (head + off) % CAPACITY;
  endfunction

  function automatic void add_result(input status_e st, input logic signed [DATA_W-1:0] v,
                                     input logic lst);
    deque_result_t r;
    r.status = st;
    r.value  = v;
    r.last   = lst;
    predicted.push_back(r);
    if (st == ST_EMPTY) empty_reports++;
    if (st == ST_FULL) refused_inserts++;
  endfunction

  // Work out the results of one request and advance the shadow deque
  function automatic void predict_deque_op(input logic [2:0] m,
                                           input logic signed [DATA_W-1:0] v);
    bit hit;
    predicted.delete();
    case (m) inside
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (occupancy >= CAPACITY) begin
          add_result(ST_FULL, '0, 1'b1);
        end else begin
          if (m == MODE_INS_FRONT) begin
            head = (head + CAPACITY - 1) % CAPACITY;
            entries[head] = v;
          end else begin
            entries[slot(occupancy)] = v;
          end
          occupancy++;
          if (occupancy > peak_occupancy) peak_occupancy = occupancy;
          add_result(ST_DONE, '0, 1'b1);
        end
      end
      MODE_REM_FRONT, MODE_REM_BACK: begin
        if (occupancy == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else if (m == MODE_REM_FRONT) begin
          add_result(ST_DONE, entries[head], 1'b1);
          head = slot(1);
          occupancy--;
        end else begin
          add_result(ST_DONE, entries[slot(occupancy - 1)], 1'b1);
          occupancy--;
        end
      end
      MODE_SEARCH: begin
        if (occupancy == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          hit = 1'b0;
          for (int unsigned i = 0; i < occupancy; i++) begin
            if (entries[slot(i)] == v) hit = 1'b1;
          end
          add_result(hit ? ST_FOUND : ST_MISSING, v, 1'b1);
        end
      end
      MODE_DUMP: begin
        if (occupancy == 0) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < occupancy; i++) begin
            add_result(ST_DONE, entries[slot(i)], (i + 1 == occupancy));
          end
        end
      end
      default: begin
        add_result(ST_INVALID, '0, 1'b1);
      end
    endcase
  endfunction

  // Offer one request, hold it until taken, then queue what it should produce
  task automatic send_request(input logic [2:0] m, input logic signed [DATA_W-1:0] v,
                              input bit typed, input deque_result_t typed_res);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    value_in <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    predict_deque_op(m, v);
    if (typed) begin
      expected_results.push_back(typed_res);
    end else begin
      foreach (predicted[k]) expected_results.push_back(predicted[k]);
    end
  endtask

  // Random request; a filling stretch leans on inserts, a draining one on removes
  task automatic random_request(input bit filling);
    int unsigned pick;
    logic [2:0] m;
    logic signed [DATA_W-1:0] v;
    pick = $urandom_range(99);
    if (pick < 4) begin
      m = $urandom_range(1) ? MODE_RSVD_6 : MODE_RSVD_7;
    end else if (pick < 12) begin
      m = MODE_DUMP;
    end else if (pick < 28) begin
      m = MODE_SEARCH;
    end else if (pick < (filling ? 88 : 48)) begin
      m = $urandom_range(1) ? MODE_INS_FRONT : MODE_INS_BACK;
    end else begin
      m = $urandom_range(1) ? MODE_REM_FRONT : MODE_REM_BACK;
    end
    case ($urandom_range(7))
      0:       v = 32'sh7FFFFFFF;
      1:       v = 32'sh80000000;
      2:       v = $urandom_range(3);
      default: v = $urandom();
    endcase
    // Aim half the searches at a key that is present
    if (m == MODE_SEARCH && occupancy != 0 && $urandom_range(1)) begin
      v = entries[slot($urandom_range(occupancy - 1))];
    end
    send_request(m, v, 1'b0, '0);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int stall_left;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
        while (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left--;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check each result taken against the oldest outstanding expectation
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%0d last=%0b",
                                  status, value_out, last));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.status == ST_DONE && !want.last) dump_lines++;
        if (status !== want.status || value_out !== want.value || last !== want.last) begin
          report_mismatch($sformatf("got status=%0d value=%0d last=%0b, want %0d/%0d/%0b",
                                    status, value_out, last, want.status, want.value,
                                    want.last));
        end
      end
    end
  end

  initial begin
    deque_result_t typed_res;
    int wait_cycles;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under light sender and heavy receiver idling
    tx_idle_pct = 12;
    rx_idle_pct = 68;
    foreach (directed_rows[r]) begin
      for (int n = 0; n < directed_rows[r].reps; n++) begin
        typed_res.status = directed_rows[r].status;
        typed_res.value  = directed_rows[r].result;
        typed_res.last   = 1'b1;
        send_request(directed_rows[r].mode, directed_rows[r].value + n,
                     directed_rows[r].typed, typed_res);
      end
    end

    // Random requests over three idling regimes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        1: begin
          tx_idle_pct = 68;
          rx_idle_pct = 12;
          hold_go     = 1'b1;
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        default: ;
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        random_request(((n / 11) % 2) == 0);
      end
    end
    in_valid <= 1'b0;

    // Drain what is still owed, then watch for stray results
    wait_cycles = 0;
    while (expected_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    end

    $display("tb: %0d requests, %0d results checked, %0d non-final dump entries",
             requests_sent, results_checked, dump_lines);
    $display("tb: peak fill %0d of %0d, %0d refused inserts, %0d empty reports",
             peak_occupancy, CAPACITY, refused_inserts, empty_reports);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: watchdog expired");
    $display("tb: done, errors");
    $finish;
  end

endmodule
